// ----- rtl/fsiq_pkg.sv -----
`default_nettype none
package fsiq_pkg;
    localparam logic [31:0] SCALE_RESET = 32'h462AA800;
    localparam logic        WIDE_RESET  = 1'b1;
    localparam logic        CFG_SCALE   = 1'b0;
    localparam logic        CFG_WIDE    = 1'b1;

    // stage 1 to stage 2: decoded operands and exact product
    typedef struct packed {
        logic        vld;
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic        wide;
        logic [9:0]  expn;   // sum of biased exponents (bias 254 in total)
        logic [47:0] mant;
    } t_s1;

    // stage 2 to stage 3: rounded magnitude in 17 bits, big flags overflow
    typedef struct packed {
        logic        vld;
        logic        nan;
        logic        sign;
        logic        wide;
        logic        big;
        logic [16:0] mag;
    } t_s2;
endpackage
`default_nettype wire

// ----- rtl/fsiq_mul.sv -----
`default_nettype none
module fsiq_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic        i_wide,
    output fsiq_pkg::t_s1    o_s1
);
    import fsiq_pkg::*;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [9:0]  ea, eb;
    t_s1         r_s1, n_s1;

    // decode operands, subnormals get exponent 1 and no hidden bit
    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        ma = {(i_a[30:23] != 8'd0), i_a[22:0]};
        mb = {(i_b[30:23] != 8'd0), i_b[22:0]};
        ea = {2'b00, (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23]};
        eb = {2'b00, (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23]};
        n_s1.vld  = i_vld;
        n_s1.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        n_s1.inf  = a_inf || b_inf;
        n_s1.zero = a_zero || b_zero;
        n_s1.sign = i_a[31] ^ i_b[31];
        n_s1.wide = i_wide;
        n_s1.expn = ea + eb;
        n_s1.mant = ma * mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= n_s1.vld;
        end
        r_s1.nan  <= n_s1.nan;
        r_s1.inf  <= n_s1.inf;
        r_s1.zero <= n_s1.zero;
        r_s1.sign <= n_s1.sign;
        r_s1.wide <= n_s1.wide;
        r_s1.expn <= n_s1.expn;
        r_s1.mant <= n_s1.mant;
    end
    assign o_s1 = r_s1;
endmodule
`default_nettype wire

// ----- rtl/fsiq_rnd.sv -----
`default_nettype none
module fsiq_rnd (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  fsiq_pkg::t_s1 i_s1,
    output fsiq_pkg::t_s2 o_s2
);
    import fsiq_pkg::*;
    // value = mant * 2^(expn - 254 - 46); integer part when shift >= 0 left
    logic [10:0] sh;       // right shift amount = 300 - expn
    logic [47:0] ip;
    logic        half;
    logic [48:0] rnd;
    t_s2         r_s2, n_s2;

    always_comb begin
        sh   = 11'd300 - {1'b0, i_s1.expn};
        ip   = 48'd0;
        half = 1'b0;
        n_s2.big = 1'b0;
        if (i_s1.expn >= 10'd300) begin
            // 2^expn-300 times mant >= 2^46 when nonzero: far beyond 16 bits
            n_s2.big = (i_s1.mant != 48'd0);
        end else if (sh <= 11'd48) begin
            ip   = i_s1.mant >> sh[5:0];
            half = (sh == 11'd0) ? 1'b0 : i_s1.mant[sh[5:0] - 6'd1];
        end
        rnd = {1'b0, ip} + {48'd0, half};
        if (rnd[48:17] != 32'd0) n_s2.big = 1'b1;
        if (i_s1.inf) n_s2.big = 1'b1;
        n_s2.mag  = i_s1.zero ? 17'd0 : rnd[16:0];
        n_s2.vld  = i_s1.vld;
        n_s2.nan  = i_s1.nan;
        n_s2.sign = i_s1.sign;
        n_s2.wide = i_s1.wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else begin
            r_s2.vld <= n_s2.vld;
        end
        r_s2.nan  <= n_s2.nan;
        r_s2.sign <= n_s2.sign;
        r_s2.wide <= n_s2.wide;
        r_s2.big  <= n_s2.big;
        r_s2.mag  <= n_s2.mag;
    end
    assign o_s2 = r_s2;
endmodule
`default_nettype wire

// ----- rtl/float_sample_int_quantizer.sv -----
`default_nettype none
// float to int8/int16 quantizer
// start with busy low accepts one sample item per cycle; busy is always low
// item: i_sample_bits, an ieee single sample, multiplied by the scale register
// result: o_quantized, o_was_nan, o_clipped, shown for one cycle with o_done
// throughput one item per cycle through the three register stages:
// multiply, shift/round, clamp
// config: i_cfg_we with i_cfg_idx 0 writes scale, 1 writes wide mode
// reset: scale 10922.0, int16 mode, pipeline emptied
// the receiver cannot stall; results are never held back
module float_sample_int_quantizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output wire logic        busy,
    input  wire logic [31:0] i_sample_bits,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output wire logic        o_done,
    output wire logic signed [15:0] o_quantized,
    output wire logic        o_was_nan,
    output wire logic        o_clipped
);
    import fsiq_pkg::*;
    logic [31:0] r_scale;
    logic        r_wide;
    t_s1         s1;
    t_s2         s2;
    logic        r_vld, n_vld;
    logic [15:0] r_q, n_q;
    logic        r_nan, n_nan, r_clip, n_clip;
    logic [16:0] hi;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_wide  <= WIDE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data;
                CFG_WIDE:  r_wide  <= i_cfg_data[0];
                default:   r_wide  <= r_wide;
            endcase
        end
    end

    assign busy = 1'b0;

    fsiq_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start),
        .i_a(i_sample_bits), .i_b(r_scale), .i_wide(r_wide), .o_s1(s1));
    fsiq_rnd u_rnd (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_s1(s1), .o_s2(s2));

    // clamp to symmetric range and apply sign; nan gives the most negative code
    always_comb begin
        hi     = s2.wide ? 17'd32767 : 17'd127;
        n_vld  = s2.vld;
        n_nan  = s2.nan;
        n_clip = 1'b0;
        n_q    = 16'd0;
        if (s2.nan) begin
            n_q = s2.wide ? 16'h8000 : 16'hFF80;
        end else if (s2.big || s2.mag > hi) begin
            n_clip = 1'b1;
            n_q    = s2.sign ? (16'd0 - hi[15:0]) : hi[15:0];
        end else begin
            n_q = s2.sign ? (16'd0 - s2.mag[15:0]) : s2.mag[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_q    <= n_q;
        r_nan  <= n_nan;
        r_clip <= n_clip;
    end

    assign o_done      = r_vld;
    assign o_quantized = r_q;
    assign o_was_nan   = r_nan;
    assign o_clipped   = r_clip;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_done) else $error("result lost");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_was_nan && o_clipped)) else $error("nan and clip");
    a_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_was_nan) |-> (r_q != 16'h8000)) else $error("sentinel");
endmodule
`default_nettype wire
